// ----- rtl/tsq_pkg.sv -----
// types and constants shared by the transmit slot queue
// no dependencies
package tsq_pkg;

  localparam logic [1:0] KIND_ENQ  = 2'd0;
  localparam logic [1:0] KIND_PUMP = 2'd1;
  localparam logic [1:0] KIND_ACK  = 2'd2;
  localparam logic [1:0] KIND_TICK = 2'd3;

  localparam logic [1:0] CMD_OK    = 2'd0;
  localparam logic [1:0] CMD_FATAL = 2'd2;

  localparam logic [15:0] ACK_TIMEOUT_RST = 16'd5000;
  localparam logic [15:0] ELAPSED_MAX     = 16'hffff;

  typedef enum logic [1:0] {
    SLOT_FREE = 2'd0,
    SLOT_PEND = 2'd1,
    SLOT_WAIT = 2'd2
  } slot_state_e;

  typedef enum logic [2:0] {
    EV_ACCEPT = 3'd0,
    EV_REJECT = 3'd1,
    EV_TX     = 3'd2,
    EV_OK     = 3'd3,
    EV_FAIL   = 3'd4,
    EV_RETRY  = 3'd5,
    EV_NONE   = 3'd6
  } event_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ENQ,
    ST_TICK,
    ST_ACK,
    ST_PUMP_TO,
    ST_PUMP_IS,
    ST_EMIT_B
  } state_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  link;
    logic [11:0] length;
    logic [7:0]  retries;
    logic [1:0]  cmd_result;
    logic        write_ok;
    logic        ack_ok;
  } req_t;

  typedef struct packed {
    logic [2:0]  event_res;
    logic [2:0]  slot;
    logic [2:0]  out_link;
    logic [11:0] out_length;
    logic        busy_res;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [7:0]  retries;
    logic [11:0] length;
    logic [2:0]  link;
  } slot_info_t;

endpackage

// ----- rtl/tsq_slot_mem.sv -----
// slot info memory: one write port, one read port, registered read data
// no dependencies
module tsq_slot_mem #(
  parameter int unsigned DEPTH = 8,
  parameter int unsigned WIDTH = 23
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/tsq_first_find.sv -----
// lowest set bit search over the slot flag vector
// no dependencies
module tsq_first_find #(
  parameter int unsigned N = 8
) (
  input  logic [N-1:0]                       vec_i,
  output logic [(N > 1 ? $clog2(N) : 1)-1:0] idx_o,
  output logic                               found_o
);

  localparam int unsigned IW = (N > 1) ? $clog2(N) : 1;

  always_comb begin
    idx_o   = '0;
    found_o = 1'b0;
    for (int i = N - 1; i >= 0; i--) begin
      if (vec_i[i]) begin
        idx_o   = IW'(i);
        found_o = 1'b1;
      end
    end
  end

endmodule

// ----- rtl/stop_and_wait_tx_slot_queue.sv -----
// stop-and-wait transmit slot queue, top level
// uses tsq_pkg, tsq_slot_mem and tsq_first_find
//
// A request is taken when start is high and busy is low; each result appears on res_o for
// one cycle with res_valid_o high and cannot be held off, so the receiver must take it then.
// Enqueue, acknowledgement and tick requests give one result, formed in their own state and
// registered onto res_o, and free the block for the next request as it appears. A pump
// passes ST_PUMP_TO, ST_PUMP_IS and, when a timeout and an issue both report, ST_EMIT_B: it
// needs two dependent reads of the slot info memory (in-flight slot, then lowest pending
// slot). Slot states sit in flip-flops cleared by reset, so no clearing pass follows reset.
module stop_and_wait_tx_slot_queue #(
  parameter int unsigned SLOTS   = 8,
  parameter int unsigned MAX_LEN = 2048
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  tsq_pkg::req_t req_i,
  output logic          res_valid_o,
  output tsq_pkg::res_t res_o,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [15:0]   cfg_data_i
);

  localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned MW = $bits(tsq_pkg::slot_info_t);

  function automatic logic [2:0] slot3(logic [IW-1:0] s);
    logic [IW+2:0] e;
    e = {3'b000, s};
    return e[2:0];
  endfunction

  tsq_pkg::state_e      state_q, state_d;
  tsq_pkg::slot_state_e status_q [SLOTS];
  tsq_pkg::slot_state_e status_d [SLOTS];
  logic                 ifv_q, ifv_d;
  logic [IW-1:0]        ifs_q, ifs_d;
  logic [15:0]          elapsed_q, elapsed_d;
  logic [15:0]          timeout_q;

  tsq_pkg::req_t        req_q, req_d;
  tsq_pkg::res_t        resa_q, resa_d;
  logic                 resa_vld_q, resa_vld_d;
  tsq_pkg::res_t        resb_q, resb_d;
  logic [IW-1:0]        iss_slot_q, iss_slot_d;
  logic                 iss_vld_q, iss_vld_d;
  logic                 fwd_hit_q;
  tsq_pkg::slot_info_t  fwd_data_q;

  tsq_pkg::res_t        core;
  logic                 core_vld;
  logic                 busy_next;
  logic                 res_valid_q;
  tsq_pkg::res_t        res_q, res_d;

  logic                 we, re;
  logic [IW-1:0]        waddr, raddr;
  tsq_pkg::slot_info_t  wdata;
  logic [MW-1:0]        rdata;
  tsq_pkg::slot_info_t  rd_info;

  logic [SLOTS-1:0]     free_vec, pend_vec, wait_vec;
  logic [IW-1:0]        free_idx, pend_idx;
  logic                 free_any, pend_any;
  logic                 to_fire, to_retry, len_ok;

  assign rd_info = tsq_pkg::slot_info_t'(rdata);

  tsq_slot_mem #(
    .DEPTH(SLOTS),
    .WIDTH(MW)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(MW'(wdata)),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // timeout check and the slot vectors seen after it
  assign to_fire  = ifv_q && (elapsed_q > timeout_q);
  assign to_retry = (rd_info.retries != 8'd0);
  assign len_ok   = (req_q.length != 12'd0) && (req_q.length <= 12'(MAX_LEN));

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      free_vec[i] = (status_q[i] == tsq_pkg::SLOT_FREE);
      wait_vec[i] = (status_q[i] == tsq_pkg::SLOT_WAIT);
      pend_vec[i] = (status_q[i] == tsq_pkg::SLOT_PEND) ||
                    (to_fire && to_retry && (ifs_q == IW'(i)));
    end
  end

  tsq_first_find #(.N(SLOTS)) u_free_find (
    .vec_i  (free_vec),
    .idx_o  (free_idx),
    .found_o(free_any)
  );

  tsq_first_find #(.N(SLOTS)) u_pend_find (
    .vec_i  (pend_vec),
    .idx_o  (pend_idx),
    .found_o(pend_any)
  );

  always_comb begin
    tsq_pkg::slot_info_t info;
    tsq_pkg::res_t       b;
    state_d    = state_q;
    status_d   = status_q;
    ifv_d      = ifv_q;
    ifs_d      = ifs_q;
    elapsed_d  = elapsed_q;
    req_d      = req_q;
    resa_d     = resa_q;
    resa_vld_d = resa_vld_q;
    resb_d     = resb_q;
    iss_slot_d = iss_slot_q;
    iss_vld_d  = iss_vld_q;
    core       = '0;
    core_vld   = 1'b0;
    we         = 1'b0;
    waddr      = ifs_q;
    wdata      = rd_info;
    re         = 1'b0;
    raddr      = ifs_q;
    info       = rd_info;
    b          = '0;
    case (state_q)
      tsq_pkg::ST_IDLE: begin
        if (start) begin
          req_d = req_i;
          re    = 1'b1;
          raddr = ifs_q;
          case (req_i.kind)
            tsq_pkg::KIND_ENQ:  state_d = tsq_pkg::ST_ENQ;
            tsq_pkg::KIND_PUMP: state_d = tsq_pkg::ST_PUMP_TO;
            tsq_pkg::KIND_ACK:  state_d = tsq_pkg::ST_ACK;
            default:            state_d = tsq_pkg::ST_TICK;
          endcase
        end
      end
      tsq_pkg::ST_ENQ: begin
        core.out_link = req_q.link;
        if (len_ok && free_any) begin
          we                 = 1'b1;
          waddr              = free_idx;
          wdata.retries      = req_q.retries;
          wdata.length       = req_q.length;
          wdata.link         = req_q.link;
          status_d[free_idx] = tsq_pkg::SLOT_PEND;
          core.event_res     = tsq_pkg::EV_ACCEPT;
          core.slot          = slot3(free_idx);
        end else begin
          core.event_res = tsq_pkg::EV_REJECT;
        end
        core.last = 1'b1;
        core_vld  = 1'b1;
        state_d   = tsq_pkg::ST_IDLE;
      end
      tsq_pkg::ST_TICK: begin
        if (ifv_q && (elapsed_q != tsq_pkg::ELAPSED_MAX)) begin
          elapsed_d = elapsed_q + 16'd1;
        end
        core.event_res = tsq_pkg::EV_NONE;
        core.last      = 1'b1;
        core_vld       = 1'b1;
        state_d        = tsq_pkg::ST_IDLE;
      end
      tsq_pkg::ST_ACK: begin
        if (ifv_q) begin
          core.slot     = slot3(ifs_q);
          core.out_link = info.link;
          if (req_q.ack_ok) begin
            status_d[ifs_q] = tsq_pkg::SLOT_FREE;
            core.event_res  = tsq_pkg::EV_OK;
          end else if (info.retries != 8'd0) begin
            we              = 1'b1;
            waddr           = ifs_q;
            wdata.retries   = info.retries - 8'd1;
            status_d[ifs_q] = tsq_pkg::SLOT_PEND;
            core.event_res  = tsq_pkg::EV_RETRY;
          end else begin
            status_d[ifs_q] = tsq_pkg::SLOT_FREE;
            core.event_res  = tsq_pkg::EV_FAIL;
          end
          ifv_d = 1'b0;
        end else begin
          core.event_res = tsq_pkg::EV_NONE;
        end
        core.last = 1'b1;
        core_vld  = 1'b1;
        state_d   = tsq_pkg::ST_IDLE;
      end
      tsq_pkg::ST_PUMP_TO: begin
        resa_vld_d        = to_fire;
        resa_d            = '0;
        resa_d.slot       = slot3(ifs_q);
        resa_d.out_link   = info.link;
        if (to_fire) begin
          if (to_retry) begin
            we               = 1'b1;
            waddr            = ifs_q;
            wdata.retries    = info.retries - 8'd1;
            status_d[ifs_q]  = tsq_pkg::SLOT_PEND;
            resa_d.event_res = tsq_pkg::EV_RETRY;
          end else begin
            status_d[ifs_q]  = tsq_pkg::SLOT_FREE;
            resa_d.event_res = tsq_pkg::EV_FAIL;
          end
          ifv_d = 1'b0;
        end
        iss_vld_d  = (!ifv_q || to_fire) && pend_any;
        iss_slot_d = pend_idx;
        re         = 1'b1;
        raddr      = pend_idx;
        state_d    = tsq_pkg::ST_PUMP_IS;
      end
      tsq_pkg::ST_PUMP_IS: begin
        info       = fwd_hit_q ? fwd_data_q : rd_info;
        b.slot     = slot3(iss_slot_q);
        b.out_link = info.link;
        if (iss_vld_q) begin
          if (req_q.cmd_result == tsq_pkg::CMD_OK) begin
            if (req_q.write_ok) begin
              status_d[iss_slot_q] = tsq_pkg::SLOT_WAIT;
              ifv_d                = 1'b1;
              ifs_d                = iss_slot_q;
              elapsed_d            = '0;
              b.event_res          = tsq_pkg::EV_TX;
              b.out_length         = info.length;
            end else begin
              status_d[iss_slot_q] = tsq_pkg::SLOT_FREE;
              b.event_res          = tsq_pkg::EV_FAIL;
            end
          end else if (req_q.cmd_result == tsq_pkg::CMD_FATAL ||
                       info.retries == 8'd0) begin
            status_d[iss_slot_q] = tsq_pkg::SLOT_FREE;
            b.event_res          = tsq_pkg::EV_FAIL;
          end else begin
            we            = 1'b1;
            waddr         = iss_slot_q;
            wdata         = info;
            wdata.retries = info.retries - 8'd1;
            b.event_res   = tsq_pkg::EV_RETRY;
          end
        end
        b.last   = 1'b1;
        resb_d   = b;
        core_vld = 1'b1;
        if (resa_vld_q) begin
          core      = resa_q;
          core.last = !iss_vld_q;
          state_d   = iss_vld_q ? tsq_pkg::ST_EMIT_B : tsq_pkg::ST_IDLE;
        end else if (iss_vld_q) begin
          core    = b;
          state_d = tsq_pkg::ST_IDLE;
        end else begin
          core.event_res = tsq_pkg::EV_NONE;
          core.last      = 1'b1;
          state_d        = tsq_pkg::ST_IDLE;
        end
      end
      tsq_pkg::ST_EMIT_B: begin
        core      = resb_q;
        core.last = 1'b1;
        core_vld  = 1'b1;
        state_d   = tsq_pkg::ST_IDLE;
      end
      default: begin
        state_d = tsq_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    busy_next = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      if (status_d[i] != tsq_pkg::SLOT_FREE) begin
        busy_next = 1'b1;
      end
    end
    res_d          = core;
    res_d.busy_res = busy_next;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tsq_pkg::ST_IDLE;
      for (int i = 0; i < SLOTS; i++) begin
        status_q[i] <= tsq_pkg::SLOT_FREE;
      end
      ifv_q       <= 1'b0;
      ifs_q       <= '0;
      elapsed_q   <= '0;
      timeout_q   <= tsq_pkg::ACK_TIMEOUT_RST;
      resa_vld_q  <= 1'b0;
      iss_vld_q   <= 1'b0;
      fwd_hit_q   <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      status_q    <= status_d;
      ifv_q       <= ifv_d;
      ifs_q       <= ifs_d;
      elapsed_q   <= elapsed_d;
      resa_vld_q  <= resa_vld_d;
      iss_vld_q   <= iss_vld_d;
      fwd_hit_q   <= we && re && (waddr == raddr);
      res_valid_q <= core_vld;
      if (cfg_valid_i && cfg_ready_o) begin
        timeout_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q        <= req_d;
    resa_q       <= resa_d;
    resb_q       <= resb_d;
    iss_slot_q   <= iss_slot_d;
    fwd_data_q   <= wdata;
    res_q        <= res_d;
  end

  assign busy        = (state_q != tsq_pkg::ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  a_inflight_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ifv_q |-> (status_q[ifs_q] == tsq_pkg::SLOT_WAIT))
    else $error("in-flight slot not awaiting acknowledgement");

  a_one_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($countones(wait_vec) <= 1) && (($countones(wait_vec) == 1) == ifv_q))
    else $error("waiting slots disagree with in-flight state");

  a_second_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_o.last) |=> (res_valid_o && res_o.last))
    else $error("first of two results not followed by the last one");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("request accepted without going busy");

endmodule

// ----- sim/tsq_result_checker.sv -----
`timescale 1ns / 100ps
// result checker for the stop-and-wait transmit slot queue: tracks slot state from
// accepted requests and config writes, compares every result strobe in order
// depends on tsq_pkg
module tsq_result_checker
  import tsq_pkg::*;
#(
  parameter int unsigned SLOTS   = 8,
  parameter int unsigned MAX_LEN = 2048
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  input  logic        busy,
  input  req_t        req_i,
  input  logic        res_valid_i,
  input  res_t        res_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [15:0] cfg_data_i,
  output int          errors_o,
  output int          pending_o
);

  slot_state_e slot_st   [SLOTS];
  slot_info_t  slot_info [SLOTS];
  logic        fly_valid;
  logic [2:0]  fly_slot;
  logic [15:0] elapsed;
  logic [15:0] ack_limit;
  res_t        due_results [$];
  int          errors = 0;

  assign errors_o = errors;

  function automatic string res_text(input res_t r);
    return $sformatf("ev %0d slot %0d link %0d len %0d busy %0b last %0b",
                     r.event_res, r.slot, r.out_link, r.out_length, r.busy_res, r.last);
  endfunction

  task automatic flag(input string what);
    errors++;
    if (errors <= 10) begin
      $display("%0t: %s", $time, what);
    end
  endtask

  function automatic res_t make_res(input event_e ev, input int s, input logic [2:0] lk,
                                    input logic [11:0] len);
    res_t r;
    r = '0;
    r.event_res  = ev;
    r.slot       = 3'(s);
    r.out_link   = lk;
    r.out_length = len;
    return r;
  endfunction

  // failed attempt: back to pending while resends remain, else released
  function automatic event_e retire_or_requeue(input int s);
    event_e ev;
    if (slot_info[s].retries != 8'd0) begin
      slot_info[s].retries = slot_info[s].retries - 8'd1;
      slot_st[s] = SLOT_PEND;
      ev = EV_RETRY;
    end else begin
      slot_st[s] = SLOT_FREE;
      ev = EV_FAIL;
    end
    if (fly_valid && fly_slot == 3'(s)) begin
      fly_valid = 1'b0;
    end
    return ev;
  endfunction

  task automatic step_slot_model(input req_t r);
    res_t   outs [$];
    res_t   one;
    event_e ev;
    int     s;
    logic   occupied;
    outs = {};
    case (r.kind)
      KIND_ENQ: begin
        s = SLOTS;
        if (r.length != 12'd0 && r.length <= MAX_LEN) begin
          for (int i = SLOTS - 1; i >= 0; i--) begin
            if (slot_st[i] == SLOT_FREE) s = i;
          end
        end
        if (s == SLOTS) begin
          outs.push_back(make_res(EV_REJECT, 0, r.link, '0));
        end else begin
          slot_info[s].link    = r.link;
          slot_info[s].length  = r.length;
          slot_info[s].retries = r.retries;
          slot_st[s] = SLOT_PEND;
          outs.push_back(make_res(EV_ACCEPT, s, r.link, '0));
        end
      end
      KIND_PUMP: begin
        if (fly_valid && elapsed > ack_limit) begin
          s = fly_slot;
          ev = retire_or_requeue(s);
          fly_valid = 1'b0;
          outs.push_back(make_res(ev, s, slot_info[s].link, '0));
        end
        if (!fly_valid) begin
          s = SLOTS;
          for (int i = SLOTS - 1; i >= 0; i--) begin
            if (slot_st[i] == SLOT_PEND) s = i;
          end
          if (s != SLOTS) begin
            if (r.cmd_result == CMD_OK && r.write_ok) begin
              slot_st[s] = SLOT_WAIT;
              fly_valid  = 1'b1;
              fly_slot   = 3'(s);
              elapsed    = '0;
              outs.push_back(make_res(EV_TX, s, slot_info[s].link, slot_info[s].length));
            end else begin
              if (r.cmd_result == CMD_OK || r.cmd_result == CMD_FATAL) begin
                slot_st[s] = SLOT_FREE;
                ev = EV_FAIL;
              end else begin
                ev = retire_or_requeue(s);
              end
              outs.push_back(make_res(ev, s, slot_info[s].link, '0));
            end
          end
        end
        if (outs.size() == 0) begin
          outs.push_back(make_res(EV_NONE, 0, '0, '0));
        end
      end
      KIND_ACK: begin
        if (fly_valid) begin
          s = fly_slot;
          if (r.ack_ok) begin
            slot_st[s] = SLOT_FREE;
            ev = EV_OK;
          end else begin
            ev = retire_or_requeue(s);
          end
          fly_valid = 1'b0;
          outs.push_back(make_res(ev, s, slot_info[s].link, '0));
        end else begin
          outs.push_back(make_res(EV_NONE, 0, '0, '0));
        end
      end
      default: begin
        if (fly_valid && elapsed != ELAPSED_MAX) begin
          elapsed = elapsed + 16'd1;
        end
        outs.push_back(make_res(EV_NONE, 0, '0, '0));
      end
    endcase
    occupied = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_st[i] != SLOT_FREE) occupied = 1'b1;
    end
    foreach (outs[k]) begin
      one = outs[k];
      one.busy_res = occupied;
      one.last     = (k == outs.size() - 1);
      due_results.push_back(one);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_st[i]   = SLOT_FREE;
        slot_info[i] = '0;
      end
      fly_valid = 1'b0;
      fly_slot  = '0;
      elapsed   = '0;
      ack_limit = ACK_TIMEOUT_RST;
      due_results.delete();
      pending_o <= 0;
    end else begin
      if (res_valid_i) begin
        if (due_results.size() == 0) begin
          flag($sformatf("unexpected result: %s", res_text(res_i)));
        end else begin
          if (res_i !== due_results[0]) begin
            flag($sformatf("mismatch: expected %s, got %s",
                           res_text(due_results[0]), res_text(res_i)));
          end
          void'(due_results.pop_front());
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        ack_limit = cfg_data_i;
      end
      if (start && !busy) begin
        step_slot_model(req_i);
      end
      pending_o <= due_results.size();
    end
  end

endmodule

// ----- sim/stop_and_wait_tx_slot_queue_test.sv -----
`timescale 1ns / 100ps
// testbench top for the stop-and-wait transmit slot queue: directed and random
// requests, ack timeout rewrites, verdict from tsq_result_checker
// depends on tsq_pkg, stop_and_wait_tx_slot_queue and tsq_result_checker
module stop_and_wait_tx_slot_queue_test;
  import tsq_pkg::*;

  localparam int unsigned SLOTS   = 8;
  localparam int unsigned MAX_LEN = 2048;
  localparam logic [1:0] CMD_RECOVER = 2'd1;
  localparam logic [1:0] CMD_SPARE   = 2'd3;
  localparam int PHASE_ITEMS = 380;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        start       = 1'b0;
  logic        busy;
  req_t        req_i       = '0;
  logic        res_valid_o;
  res_t        res_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i  = '0;
  int          errors;
  int          pending;
  int          quiet = 0;

  stop_and_wait_tx_slot_queue #(.SLOTS(SLOTS), .MAX_LEN(MAX_LEN)) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .res_valid_o(res_valid_o),
    .res_o      (res_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  tsq_result_checker #(.SLOTS(SLOTS), .MAX_LEN(MAX_LEN)) checker_i (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .res_valid_i(res_valid_o),
    .res_i      (res_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_i(cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .errors_o   (errors),
    .pending_o  (pending)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic req_t req_of(input logic [1:0] kind, input logic [2:0] link,
                                  input logic [11:0] length, input logic [7:0] retries,
                                  input logic [1:0] cmd, input logic wok, input logic aok);
    req_t r;
    r.kind       = kind;
    r.link       = link;
    r.length     = length;
    r.retries    = retries;
    r.cmd_result = cmd;
    r.write_ok   = wok;
    r.ack_ok     = aok;
    return r;
  endfunction

  function automatic req_t random_request();
    req_t r;
    int   pick;
    pick = $urandom_range(0, 99);
    if (pick < 30) r.kind = KIND_ENQ;
    else if (pick < 60) r.kind = KIND_PUMP;
    else if (pick < 75) r.kind = KIND_ACK;
    else r.kind = KIND_TICK;
    r.link = 3'($urandom_range(0, 7));
    pick = $urandom_range(0, 99);
    if (pick < 80) r.length = 12'($urandom_range(1, MAX_LEN));
    else if (pick < 85) r.length = '0;
    else if (pick < 90) r.length = 12'(MAX_LEN);
    else r.length = 12'($urandom_range(0, 4095));
    pick = $urandom_range(0, 99);
    if (pick < 70) r.retries = 8'($urandom_range(0, 3));
    else if (pick < 85) r.retries = '0;
    else r.retries = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 99) < 60) r.cmd_result = CMD_OK;
    else r.cmd_result = 2'($urandom_range(0, 3));
    r.write_ok = ($urandom_range(0, 9) != 0);
    r.ack_ok   = ($urandom_range(0, 3) != 0);
    return r;
  endfunction

  // holds start until the request is taken
  task automatic issue(input req_t r);
    req_i <= r;
    start <= 1'b1;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic send_request(input req_t r);
    int n;
    int pick;
    n = 0;
    issue(r);
    if (quiet > 0) begin
      quiet--;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 3) quiet = $urandom_range(20, 80);
      else if (pick < 45) n = 0;
      else if (pick < 90) n = $urandom_range(1, 3);
      else n = $urandom_range(4, 30);
    end
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic send_ticks(input int count);
    repeat (count) issue(req_of(KIND_TICK, '0, '0, '0, CMD_OK, 1'b1, 1'b1));
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0 || busy) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_ack_timeout(input logic [15:0] value);
    drain();
    cfg_data_i  <= value;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // empty pool, reset timeout
    send_request(req_of(KIND_ACK,  3'd1, '0, '0, CMD_OK, 1'b1, 1'b1));
    send_request(req_of(KIND_PUMP, 3'd2, '0, '0, CMD_OK, 1'b1, 1'b1));
    send_request(req_of(KIND_TICK, 3'd3, '0, '0, CMD_OK, 1'b1, 1'b1));
    send_request(req_of(KIND_ENQ,  3'd5, 12'd0, 8'd4, CMD_OK, 1'b1, 1'b1));
    send_request(req_of(KIND_ENQ,  3'd6, 12'(MAX_LEN + 1), 8'd4, CMD_OK, 1'b1, 1'b1));
    send_request(req_of(KIND_ENQ,  3'd7, 12'hfff, 8'hff, CMD_OK, 1'b1, 1'b1));
    // fill every slot
    send_request(req_of(KIND_ENQ,  3'd7, 12'(MAX_LEN), 8'hff, CMD_OK, 1'b1, 1'b1));
    send_request(req_of(KIND_ENQ,  3'd0, 12'd1, 8'd0, CMD_OK, 1'b1, 1'b1));
    send_request(req_of(KIND_ENQ,  3'd2, 12'd100, 8'd1, CMD_OK, 1'b1, 1'b1));
    send_request(req_of(KIND_ENQ,  3'd3, 12'd300, 8'd0, CMD_OK, 1'b1, 1'b1));
    send_request(req_of(KIND_ENQ,  3'd4, 12'd1234, 8'd2, CMD_OK, 1'b1, 1'b1));
    for (int i = 5; i < SLOTS; i++) begin
      send_request(req_of(KIND_ENQ, 3'(i), 12'(16 * i), 8'd0, CMD_OK, 1'b1, 1'b1));
    end
    send_request(req_of(KIND_ENQ,  3'd6, 12'd50, 8'd1, CMD_OK, 1'b1, 1'b1));
    // issue paths
    send_request(req_of(KIND_PUMP, '0, '0, '0, CMD_OK, 1'b1, 1'b1));
    send_request(req_of(KIND_PUMP, '0, '0, '0, CMD_OK, 1'b1, 1'b1));
    send_request(req_of(KIND_ACK,  '0, '0, '0, CMD_OK, 1'b1, 1'b1));
    send_request(req_of(KIND_PUMP, '0, '0, '0, CMD_FATAL, 1'b1, 1'b1));
    send_request(req_of(KIND_PUMP, '0, '0, '0, CMD_RECOVER, 1'b1, 1'b1));
    send_request(req_of(KIND_PUMP, '0, '0, '0, CMD_SPARE, 1'b1, 1'b1));
    send_request(req_of(KIND_PUMP, '0, '0, '0, CMD_OK, 1'b0, 1'b1));
    send_request(req_of(KIND_PUMP, '0, '0, '0, CMD_OK, 1'b1, 1'b1));
    send_request(req_of(KIND_ACK,  '0, '0, '0, CMD_OK, 1'b1, 1'b0));
    send_request(req_of(KIND_PUMP, '0, '0, '0, CMD_OK, 1'b1, 1'b1));
    // timeout, then retry and reissue in one pump
    set_ack_timeout(16'd3);
    send_ticks(4);
    send_request(req_of(KIND_PUMP, '0, '0, '0, CMD_OK, 1'b1, 1'b1));

    // largest timeouts hold off a short wait
    set_ack_timeout(16'hffff);
    send_ticks(8);
    send_request(req_of(KIND_PUMP, '0, '0, '0, CMD_OK, 1'b1, 1'b1));
    set_ack_timeout(16'hfffe);
    send_request(req_of(KIND_PUMP, '0, '0, '0, CMD_OK, 1'b1, 1'b1));
    set_ack_timeout(16'd0);
    send_ticks(1);
    send_request(req_of(KIND_PUMP, '0, '0, '0, CMD_OK, 1'b1, 1'b1));
    set_ack_timeout(16'd1);
    send_ticks(1);
    send_request(req_of(KIND_PUMP, '0, '0, '0, CMD_OK, 1'b1, 1'b1));
    send_ticks(1);
    send_request(req_of(KIND_PUMP, '0, '0, '0, CMD_OK, 1'b1, 1'b1));

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: set_ack_timeout(16'($urandom_range(1, 4)));
        1: set_ack_timeout(16'($urandom_range(0, 12)));
        2: set_ack_timeout(16'd0);
        3: set_ack_timeout(16'($urandom_range(5, 60)));
        default: set_ack_timeout(16'hffff);
      endcase
      repeat (PHASE_ITEMS) send_request(random_request());
    end

    drain();
    if (errors == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
